[design/fmv4_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
package fmv4_pkg;

    localparam int MAX_INPUT_LENGTH_DEF  = 4096;
    localparam int MAX_OUTPUT_LENGTH_DEF = 65536;
    localparam int IN_LEN_W   = 13;
    localparam int OUT_LEN_W  = 17;
    localparam int ADDR_W     = 3;

    localparam logic CFG_INPUT_LENGTH  = 1'b0;
    localparam logic CFG_OUTPUT_LENGTH = 1'b1;

    localparam logic [IN_LEN_W-1:0]  IN_LEN_RESET  = 13'd4;
    localparam logic [OUT_LEN_W-1:0] OUT_LEN_RESET = 17'd1;

    localparam logic [31:0] QNAN = 32'h7FC0_0000;

    typedef struct packed {
        logic        req_type;
        logic [31:0] value_bits;
    } t_in_item;

    typedef struct packed {
        logic [15:0] row_number;
        logic [31:0] result_bits;
        logic        final_row;
    } t_out_item;

    // per-column control carried along the product pipeline
    typedef struct packed {
        logic        vld;
        logic        tail;
        logic [1:0]  idx;
        logic        last;
        logic [1:0]  ntail;
        logic [15:0] row;
        logic        fin;
    } t_meta;

    // per-row control carried along the reduction pipeline
    typedef struct packed {
        logic        vld;
        logic [1:0]  ntail;
        logic [15:0] row;
        logic        fin;
    } t_info;

    // value = (sig / 2^47) * 2^(e - 127); normalize and round to nearest even
    function automatic logic [31:0] fp_round_pack(input logic sgn,
                                                  input logic signed [12:0] e,
                                                  input logic [47:0] sig);
        logic [5:0]         lz;
        logic               found;
        logic signed [12:0] ex;
        logic signed [12:0] sh;
        logic signed [12:0] rs;
        logic [47:0]        n;
        logic               sticky;
        logic               inc;
        logic [24:0]        m;
        logic [7:0]         ep;
        logic [31:0]        tot;
        lz = 6'd0;
        found = 1'b0;
        for (int i = 47; i >= 0; i--) begin
            if (!found) begin
                if (sig[i]) found = 1'b1;
                else        lz = lz + 6'd1;
            end
        end
        if (sig == 48'd0) return {sgn, 31'd0};
        ex = e - signed'({7'd0, lz});
        if (ex >= 13'sd255) return {sgn, 8'hFF, 23'd0};
        if (ex < 13'sd1) begin
            sh = e - 13'sd1;
            ex = 13'sd0;
        end else begin
            sh = signed'({7'd0, lz});
        end
        sticky = 1'b0;
        if (sh >= 13'sd0) begin
            n = sig << sh[5:0];
        end else begin
            rs = -sh;
            if (rs >= 13'sd48) begin
                n = 48'd0;
                sticky = |sig;
            end else begin
                n = sig >> rs[5:0];
                sticky = |(sig & ((48'd1 << rs[5:0]) - 48'd1));
            end
        end
        inc = n[23] & ((|n[22:0]) | sticky | n[24]);
        m   = {1'b0, n[47:24]} + {24'd0, inc};
        ep  = (ex == 13'sd0) ? 8'd0 : 8'(ex - 13'sd1);
        tot = {1'b0, ep, 23'd0} + {7'd0, m};
        if (tot >= 32'h7F80_0000) return {sgn, 8'hFF, 23'd0};
        return {sgn, tot[30:0]};
    endfunction

    function automatic logic [31:0] fp_add(input logic [31:0] a, input logic [31:0] b);
        logic [31:0] x;
        logic [31:0] y;
        logic [7:0]  ex;
        logic [7:0]  ey;
        logic [7:0]  d;
        logic [47:0] xs;
        logic [47:0] yf;
        logic [47:0] ys;
        logic [47:0] sum;
        if ((a[30:23] == 8'hFF && a[22:0] != 23'd0) ||
            (b[30:23] == 8'hFF && b[22:0] != 23'd0)) return QNAN;
        if (a[30:23] == 8'hFF) begin
            if (b[30:23] == 8'hFF && a[31] != b[31]) return QNAN;
            return a;
        end
        if (b[30:23] == 8'hFF) return b;
        if (a[30:0] < b[30:0]) begin
            x = b;
            y = a;
        end else begin
            x = a;
            y = b;
        end
        ex = (x[30:23] == 8'd0) ? 8'd1 : x[30:23];
        ey = (y[30:23] == 8'd0) ? 8'd1 : y[30:23];
        d  = ex - ey;
        xs = {1'b0, x[30:23] != 8'd0, x[22:0], 23'd0};
        yf = {1'b0, y[30:23] != 8'd0, y[22:0], 23'd0};
        if (d >= 8'd48) begin
            ys = {47'd0, |yf};
        end else begin
            ys = yf >> d[5:0];
            ys[0] = ys[0] | (|(yf & ((48'd1 << d[5:0]) - 48'd1)));
        end
        sum = (x[31] == y[31]) ? xs + ys : xs - ys;
        if (sum == 48'd0) return {x[31] & y[31], 31'd0};
        return fp_round_pack(x[31], signed'({5'd0, ex}) + 13'sd1, sum);
    endfunction

    function automatic logic [31:0] fp_canon(input logic [31:0] x);
        if (x[30:23] == 8'hFF && x[22:0] != 23'd0) return QNAN;
        return x;
    endfunction

endpackage
`default_nettype wire

[design/fmv4_ram.sv]
`timescale 1ns / 1ps
`default_nettype none
module fmv4_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_addr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) r_mem[i_addr] <= i_wdata;
        if (i_re) r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;
endmodule
`default_nettype wire

[design/fmv4_mul.sv]
`timescale 1ns / 1ps
`default_nettype none
module fmv4_mul
    import fmv4_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_en,
    input  wire logic [31:0] i_a,
    input  wire logic [31:0] i_b,
    output logic      [31:0] o_y
);
    // stage A: mantissa product; stage B: normalize and round
    logic               r_sgn;
    logic signed [12:0] r_exp;
    logic [47:0]        r_prod;
    logic               r_nan;
    logic               r_inf;
    logic [31:0]        r_y;

    logic a_nan, b_nan, a_inf, b_inf, a_zero, b_zero;
    logic [7:0] ea, eb;

    always_comb begin
        a_nan  = (i_a[30:23] == 8'hFF) && (i_a[22:0] != 23'd0);
        b_nan  = (i_b[30:23] == 8'hFF) && (i_b[22:0] != 23'd0);
        a_inf  = (i_a[30:0] == 31'h7F80_0000);
        b_inf  = (i_b[30:0] == 31'h7F80_0000);
        a_zero = (i_a[30:0] == 31'd0);
        b_zero = (i_b[30:0] == 31'd0);
        ea     = (i_a[30:23] == 8'd0) ? 8'd1 : i_a[30:23];
        eb     = (i_b[30:23] == 8'd0) ? 8'd1 : i_b[30:23];
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sgn  <= i_a[31] ^ i_b[31];
            r_exp  <= signed'({5'd0, ea}) + signed'({5'd0, eb}) - 13'sd126;
            r_prod <= {24'd0, i_a[30:23] != 8'd0, i_a[22:0]} *
                      {24'd0, i_b[30:23] != 8'd0, i_b[22:0]};
            r_nan  <= a_nan | b_nan | (a_inf & b_zero) | (b_inf & a_zero);
            r_inf  <= a_inf | b_inf;
            if (r_nan)      r_y <= QNAN;
            else if (r_inf) r_y <= {r_sgn, 8'hFF, 23'd0};
            else            r_y <= fp_round_pack(r_sgn, r_exp, r_prod);
        end
    end

    assign o_y = r_y;
endmodule
`default_nettype wire

[design/fp32_matvec_four_chain.sv]
`timescale 1ns / 1ps
`default_nettype none
// Streaming binary32 matrix-vector product y = W x, round to nearest even, each
// product rounded before it is added. Items with req_type 0 load the vector store
// (position wraps at input_length); items with req_type 1 are weights in row-major
// order. One item is taken per clock; the block only holds off input when a finished
// row result reaches the output register while the previous one is still stalled.
// A weight item passes a vector memory read, a two-stage multiplier and
// the accumulate stage; the last column of a row then goes through a six-stage
// reduction ((p0+p1)+(p2+p3), then up to three tail products) before the result
// reaches the output register. Any register write restarts the stream;
// configure only while idle. NaN results come out as 0x7FC00000.
module fp32_matvec_four_chain
    import fmv4_pkg::*;
#(
    parameter int MAX_INPUT_LENGTH  = MAX_INPUT_LENGTH_DEF,
    parameter int MAX_OUTPUT_LENGTH = MAX_OUTPUT_LENGTH_DEF
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_stall,
    input  wire t_in_item          i_in_item,
    output logic                   o_out_valid,
    input  wire logic              i_out_stall,
    output t_out_item              o_out_item,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [ADDR_W-1:0] paddr,
    input  wire logic [31:0]       pwdata,
    output logic      [31:0]       prdata,
    output logic                   pready
);
    localparam int AW  = $clog2(MAX_INPUT_LENGTH);
    localparam int LW  = AW + 1;
    localparam int RW  = (MAX_OUTPUT_LENGTH > 1) ? $clog2(MAX_OUTPUT_LENGTH) : 1;
    localparam int RLW = RW + 1;

    // configuration
    logic [IN_LEN_W-1:0]  r_in_len;
    logic [OUT_LEN_W-1:0] r_out_len;
    logic                 cfg_wr;

    // stream positions
    logic [AW-1:0] r_load;
    logic [AW-1:0] r_col;
    logic [RW-1:0] r_row;

    // accumulators: four interleaved chains plus up to three tail products
    logic [31:0] r_p [4];
    logic [31:0] r_t [3];

    // pipeline
    t_meta       r_s1, r_s2, r_s3;
    logic [31:0] r_s1_w;
    t_info       r_e0, r_e1, r_e2, r_e3, r_e4, r_e5;
    logic [31:0] r_e0_p [4];
    logic [31:0] r_e0_t [3];
    logic [31:0] r_e1_lo, r_e1_hi;
    logic [31:0] r_e1_t [3];
    logic [31:0] r_e2_c, r_e3_c, r_e4_c, r_e5_c;
    logic [31:0] r_e2_t [3];
    logic [31:0] r_e3_t [2];
    logic [31:0] r_e4_t;
    logic        r_out_vld;
    t_out_item   r_out;

    logic          en, acc_in, acc_vec, acc_w;
    logic [LW-1:0] len, n4, pos_nxt;
    logic [RLW-1:0] rows;
    logic [AW-1:0] pos, col;
    logic          col_last, row_fin;
    logic [AW-1:0] ram_addr;
    logic [31:0]   ram_rdata, prod;
    t_meta         meta0;
    logic [31:0]   acc_sum;
    logic [31:0]   n_p [4];
    logic [31:0]   n_t [3];

    assign cfg_wr = psel & penable & pwrite & pready;
    assign pready = 1'b1;
    assign prdata = (paddr[2] == CFG_OUTPUT_LENGTH) ? {15'd0, r_out_len} : {19'd0, r_in_len};

    // whole pipeline freezes only when a result would overrun a stalled output
    assign en         = !(r_out_vld && i_out_stall && r_e5.vld);
    assign o_in_stall = !en;
    assign acc_in     = i_in_valid && en;
    assign acc_vec    = acc_in && !i_in_item.req_type;
    assign acc_w      = acc_in && i_in_item.req_type;

    always_comb begin
        if (r_in_len == '0)
            len = LW'(1);
        else if (32'(r_in_len) > 32'(MAX_INPUT_LENGTH))
            len = LW'(MAX_INPUT_LENGTH);
        else
            len = LW'(r_in_len);
        if (r_out_len == '0)
            rows = RLW'(1);
        else if (32'(r_out_len) > 32'(MAX_OUTPUT_LENGTH))
            rows = RLW'(MAX_OUTPUT_LENGTH);
        else
            rows = RLW'(r_out_len);
        n4       = len & ~LW'(3);
        pos      = ({1'b0, r_load} < len) ? r_load : '0;
        pos_nxt  = {1'b0, pos} + LW'(1);
        col      = ({1'b0, r_col} < len) ? r_col : '0;
        col_last = ({1'b0, col} + LW'(1)) == len;
        row_fin  = ({1'b0, r_row} + RLW'(1)) >= rows;
        ram_addr = acc_vec ? pos : col;
        meta0.vld   = acc_w;
        meta0.tail  = {1'b0, col} >= n4;
        meta0.idx   = col[1:0];
        meta0.last  = col_last;
        meta0.ntail = len[1:0];
        meta0.row   = 16'(r_row);
        meta0.fin   = row_fin;
    end

    fmv4_ram #(
        .WIDTH (32),
        .DEPTH (MAX_INPUT_LENGTH)
    ) u_vec (
        .i_clk   (i_clk),
        .i_we    (acc_vec),
        .i_re    (acc_w),
        .i_addr  (ram_addr),
        .i_wdata (i_in_item.value_bits),
        .o_rdata (ram_rdata)
    );

    fmv4_mul u_mul (
        .i_clk (i_clk),
        .i_en  (en),
        .i_a   (r_s1_w),
        .i_b   (ram_rdata),
        .o_y   (prod)
    );

    // accumulate stage: product lands in its chain or in a tail slot
    always_comb begin
        n_p = r_p;
        n_t = r_t;
        acc_sum = fp_add(r_p[r_s3.idx], prod);
        if (r_s3.vld) begin
            if (!r_s3.tail) n_p[r_s3.idx] = acc_sum;
            else if (r_s3.idx != 2'd3) n_t[r_s3.idx] = prod;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_len  <= IN_LEN_RESET;
            r_out_len <= OUT_LEN_RESET;
            r_load    <= '0;
            r_col     <= '0;
            r_row     <= '0;
            r_p       <= '{default: '0};
            r_t       <= '{default: '0};
            r_s1      <= '0;
            r_s2      <= '0;
            r_s3      <= '0;
            r_e0      <= '0;
            r_e1      <= '0;
            r_e2      <= '0;
            r_e3      <= '0;
            r_e4      <= '0;
            r_e5      <= '0;
            r_out_vld <= 1'b0;
        end else if (cfg_wr) begin
            unique case (paddr[2])
                CFG_INPUT_LENGTH:  r_in_len  <= pwdata[IN_LEN_W-1:0];
                CFG_OUTPUT_LENGTH: r_out_len <= pwdata[OUT_LEN_W-1:0];
                default: ;
            endcase
            r_load <= '0;
            r_col  <= '0;
            r_row  <= '0;
            r_p    <= '{default: '0};
            r_t    <= '{default: '0};
        end else begin
            if (r_out_vld && !i_out_stall) r_out_vld <= 1'b0;
            if (en) begin
                if (acc_vec) r_load <= (pos_nxt >= len) ? '0 : pos_nxt[AW-1:0];
                if (acc_w) begin
                    if (col_last) begin
                        r_col <= '0;
                        r_row <= row_fin ? '0 : r_row + RW'(1);
                    end else begin
                        r_col <= col + AW'(1);
                    end
                end
                r_s1 <= meta0;
                r_s2 <= r_s1;
                r_s3 <= r_s2;
                if (r_s3.vld && r_s3.last) begin
                    r_p <= '{default: '0};
                    r_t <= '{default: '0};
                end else begin
                    r_p <= n_p;
                    r_t <= n_t;
                end
                r_e0.vld   <= r_s3.vld && r_s3.last;
                r_e0.ntail <= r_s3.ntail;
                r_e0.row   <= r_s3.row;
                r_e0.fin   <= r_s3.fin;
                r_e1 <= r_e0;
                r_e2 <= r_e1;
                r_e3 <= r_e2;
                r_e4 <= r_e3;
                r_e5 <= r_e4;
                if (r_e5.vld) r_out_vld <= 1'b1;
            end
        end
    end

    // reduction datapath
    always_ff @(posedge i_clk) begin
        if (en) begin
            if (acc_w) r_s1_w <= i_in_item.value_bits;
            r_e0_p  <= n_p;
            r_e0_t  <= n_t;
            r_e1_lo <= fp_add(r_e0_p[0], r_e0_p[1]);
            r_e1_hi <= fp_add(r_e0_p[2], r_e0_p[3]);
            r_e1_t  <= r_e0_t;
            r_e2_c  <= fp_add(r_e1_lo, r_e1_hi);
            r_e2_t  <= r_e1_t;
            r_e3_c  <= (r_e2.ntail >= 2'd1) ? fp_add(r_e2_c, r_e2_t[0]) : r_e2_c;
            r_e3_t  <= '{r_e2_t[1], r_e2_t[2]};
            r_e4_c  <= (r_e3.ntail >= 2'd2) ? fp_add(r_e3_c, r_e3_t[0]) : r_e3_c;
            r_e4_t  <= r_e3_t[1];
            r_e5_c  <= (r_e4.ntail == 2'd3) ? fp_add(r_e4_c, r_e4_t) : r_e4_c;
            if (r_e5.vld) begin
                r_out.row_number  <= r_e5.row;
                r_out.result_bits <= fp_canon(r_e5_c);
                r_out.final_row   <= r_e5.fin;
            end
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_item  = r_out;
endmodule
`default_nettype wire
